### src/anagram_group_classifier_top_assert.svh
// Assertion macros shared by the classifier modules.
`ifndef ANAGRAM_GROUP_CLASSIFIER_TOP_ASSERT_SVH
`define ANAGRAM_GROUP_CLASSIFIER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AGC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Shared constants and types of the anagram group classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package agc_pkg;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_GROUPS    = 64;
  localparam int COUNT_BITS    = 8;
  localparam int LETTER_W      = 5;
  localparam int GID_W         = 6;
  localparam int SIG_W         = ALPHABET_SIZE * COUNT_BITS;
  localparam int GRP_W         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int USED_W        = $clog2(MAX_GROUPS + 1);
  localparam int QDEPTH        = 4;
  localparam int QIDX_W        = 2;
  localparam int QCNT_W        = 3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SIG_W-1:0] sig_t;

  typedef struct packed {
    sig_t sig;
    logic sat;
    logic clr;
  } req_t;

  typedef struct packed {
    logic [GID_W-1:0] group_id;
    logic             new_group;
    logic             table_full;
    logic             too_long;
  } res_t;
endpackage
`default_nettype wire

### src/agc_ram.sv
// ----------------------------------------------------------------------------
// agc_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module agc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### src/agc_front.sv
// ----------------------------------------------------------------------------
// agc_front
// Letter counter: builds the count signature and emits a request per string.
// ----------------------------------------------------------------------------
`default_nettype none
module agc_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            take,
  input  wire logic [agc_pkg::LETTER_W-1:0]    letter,
  input  wire logic                            has_letter,
  input  wire logic                            last,
  input  wire logic                            new_set,
  output logic                                 req_valid,
  output agc_pkg::req_t                        req
);
  import agc_pkg::*;

  count_t counts [ALPHABET_SIZE];
  logic   sat;
  logic   clr_pend;
  sig_t   sig_next;
  logic   sat_next;
  logic   hit;

  always_comb begin
    sat_next = sat;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      hit = has_letter && (32'(letter) == i);
      sig_next[i*COUNT_BITS +: COUNT_BITS] = counts[i];
      if (hit) begin
        if (counts[i] == '1) begin
          sat_next = 1'b1;
        end else begin
          sig_next[i*COUNT_BITS +: COUNT_BITS] = counts[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    req_valid <= 1'b0;
    if (rst) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts[i] <= '0;
      end
      sat      <= 1'b0;
      clr_pend <= 1'b0;
    end else if (take) begin
      if (last) begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
          counts[i] <= '0;
        end
        sat       <= 1'b0;
        clr_pend  <= 1'b0;
        req_valid <= 1'b1;
        req.sig   <= sig_next;
        req.sat   <= sat_next;
        req.clr   <= clr_pend | new_set;
      end else begin
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
          counts[i] <= sig_next[i*COUNT_BITS +: COUNT_BITS];
        end
        sat      <= sat_next;
        clr_pend <= clr_pend | new_set;
      end
    end
  end

  `include "anagram_group_classifier_top_assert.svh"
  `AGC_ASSERT_NEXT(a_req_after_last, clk, rst, take && last, req_valid, "missing request")
  `AGC_ASSERT_NEXT(a_no_req, clk, rst, !(take && last), !req_valid, "stray request")
  `AGC_ASSERT_NEXT(a_sat_clear, clk, rst, take && last, !sat, "sat not cleared")
endmodule
`default_nettype wire

### src/agc_queue.sv
// ----------------------------------------------------------------------------
// agc_queue
// Short FIFO of finished-string requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module agc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire agc_pkg::req_t        din,
  input  wire logic                 pop,
  output agc_pkg::req_t             dout,
  output logic                      not_empty,
  output logic                      almost_full
);
  import agc_pkg::*;

  req_t              q [QDEPTH];
  logic [QIDX_W-1:0] wp;
  logic [QIDX_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign dout        = q[rp];
  assign not_empty   = cnt != '0;
  assign almost_full = cnt >= QCNT_W'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= din;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `include "anagram_group_classifier_top_assert.svh"
  `AGC_ASSERT_IMP(a_no_overflow, clk, rst, push, cnt < QCNT_W'(QDEPTH), "queue overflow")
  `AGC_ASSERT_IMP(a_no_underflow, clk, rst, pop, not_empty, "queue underflow")
  `AGC_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, cnt <= QCNT_W'(QDEPTH), "count out of range")
endmodule
`default_nettype wire

### src/agc_back.sv
// ----------------------------------------------------------------------------
// agc_back
// Table search, one request at a time: scans stored signatures, adds a miss.
// ----------------------------------------------------------------------------
`default_nettype none
module agc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire agc_pkg::req_t  req,
  output logic                pop,
  output logic                res_valid,
  output agc_pkg::res_t       res,
  output logic                idle
);
  import agc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} state_t;

  state_t             state;
  logic [USED_W-1:0]  used;
  logic [USED_W-1:0]  g;
  logic [GRP_W-1:0]   addr;
  logic               we;
  sig_t               rdata;
  req_t               cur;

  assign idle = state == S_IDLE;
  assign pop  = (state == S_IDLE) && req_valid;
  assign we   = (((state == S_READ) && (g >= used)) ||
                 ((state == S_CMP) && (rdata != cur.sig) && (g + 1'b1 >= used))) &&
                (used < USED_W'(MAX_GROUPS));
  assign addr = we ? used[GRP_W-1:0] : g[GRP_W-1:0];

  agc_ram #(.WIDTH(SIG_W), .DEPTH(MAX_GROUPS)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (cur.sig),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      g     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            g   <= '0;
            if (req.clr) begin
              used <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (g >= used) begin
            res_valid <= 1'b1;
            res.too_long <= cur.sat;
            if (used < USED_W'(MAX_GROUPS)) begin
              res.group_id   <= GID_W'(used);
              res.new_group  <= 1'b1;
              res.table_full <= 1'b0;
              used           <= used + 1'b1;
            end else begin
              res.group_id   <= '0;
              res.new_group  <= 1'b0;
              res.table_full <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata == cur.sig) begin
            res_valid      <= 1'b1;
            res.group_id   <= GID_W'(g);
            res.new_group  <= 1'b0;
            res.table_full <= 1'b0;
            res.too_long   <= cur.sat;
            state          <= S_IDLE;
          end else if (g + 1'b1 >= used) begin
            res_valid    <= 1'b1;
            res.too_long <= cur.sat;
            if (used < USED_W'(MAX_GROUPS)) begin
              res.group_id   <= GID_W'(used);
              res.new_group  <= 1'b1;
              res.table_full <= 1'b0;
              used           <= used + 1'b1;
            end else begin
              res.group_id   <= '0;
              res.new_group  <= 1'b0;
              res.table_full <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            g     <= g + 1'b1;
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "anagram_group_classifier_top_assert.svh"
  `AGC_ASSERT_IMP(a_used_range, clk, rst, 1'b1, used <= USED_W'(MAX_GROUPS), "used overflow")
  `AGC_ASSERT_IMP(a_full_gid, clk, rst, res_valid && res.table_full, res.group_id == '0 && !res.new_group, "bad full result")
  `AGC_ASSERT_NEXT(a_write_grows, clk, rst, we, used == $past(used) + 1'b1, "append without count")
endmodule
`default_nettype wire

### src/anagram_group_classifier_top.sv
// ----------------------------------------------------------------------------
// anagram_group_classifier_top
// Counts letters per string and classifies each string into anagram groups.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | start / busy       | letter, has_letter, last, new_set
// result   | strobe (one cycle) | group_id, new_group, table_full, too_long
//
// Letters are taken one per cycle while the request queue is not nearly full.
// A finished string holds the back end while each stored group is read and then
// compared in turn, or for one read with an empty table; the one-port signature
// RAM read sets the scan rate. busy rises while the queue is nearly full. Reset
// clears counts, queue and group count; the signature RAM needs no clearing.
// Results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module anagram_group_classifier_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [agc_pkg::LETTER_W-1:0] letter,
  input  wire logic                         has_letter,
  input  wire logic                         last,
  input  wire logic                         new_set,
  output logic                              strobe,
  output logic [agc_pkg::GID_W-1:0]         group_id,
  output logic                              new_group,
  output logic                              table_full,
  output logic                              too_long
);
  import agc_pkg::*;

  logic take, f_valid, q_ne, q_af, pop, b_idle;
  req_t f_req, q_req;
  res_t res;

  assign busy = q_af;
  assign take = start && !busy;

  agc_front u_front (
    .clk(clk), .rst(rst), .take(take), .letter(letter), .has_letter(has_letter),
    .last(last), .new_set(new_set), .req_valid(f_valid), .req(f_req)
  );

  agc_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .din(f_req), .pop(pop),
    .dout(q_req), .not_empty(q_ne), .almost_full(q_af)
  );

  agc_back u_back (
    .clk(clk), .rst(rst), .req_valid(q_ne), .req(q_req), .pop(pop),
    .res_valid(strobe), .res(res), .idle(b_idle)
  );

  assign group_id   = res.group_id;
  assign new_group  = res.new_group;
  assign table_full = res.table_full;
  assign too_long   = res.too_long;

  `include "anagram_group_classifier_top_assert.svh"
  `AGC_ASSERT_IMP(a_strobe_idle, clk, rst, strobe, b_idle, "result while busy")
  `AGC_ASSERT_IMP(a_no_take_busy, clk, rst, busy, !take, "take while busy")
  `AGC_ASSERT_IMP(a_flags, clk, rst, strobe, !(new_group && table_full), "new and full")
endmodule
`default_nettype wire
